FILE: sv/wsom_pkg.sv
package wsom_pkg;

  localparam int OPCODE_W = 2;
  localparam int HANDLE_W = 6;
  localparam int OWNER_W  = 8;
  localparam int REF_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_RAISE  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // one result word as it leaves the block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
    logic                is_top;
    logic                top_valid;
    logic [HANDLE_W-1:0] top_handle;
    logic [OWNER_W-1:0]  slot_owner_out;
    logic [REF_W-1:0]    slot_ref_out;
  } result_t;

endpackage

FILE: sv/wsom_req_if.sv
interface wsom_req_if;
  logic                          valid;
  logic                          ready;
  logic [wsom_pkg::OPCODE_W-1:0] opcode;
  logic [wsom_pkg::HANDLE_W-1:0] handle;
  logic [wsom_pkg::OWNER_W-1:0]  owner_id;
  logic [wsom_pkg::REF_W-1:0]    window_ref;

  modport source (output valid, opcode, handle, owner_id, window_ref, input ready);
  modport sink (input valid, opcode, handle, owner_id, window_ref, output ready);
endinterface

FILE: sv/wsom_rsp_if.sv
interface wsom_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wsom_pkg::STATUS_W-1:0] status;
  logic [wsom_pkg::HANDLE_W-1:0] result_handle;
  logic                          is_top;
  logic                          top_valid;
  logic [wsom_pkg::HANDLE_W-1:0] top_handle;
  logic [wsom_pkg::OWNER_W-1:0]  slot_owner_out;
  logic [wsom_pkg::REF_W-1:0]    slot_ref_out;

  modport source (output valid, status, result_handle, is_top, top_valid, top_handle,
                  slot_owner_out, slot_ref_out, input ready);
  modport sink (input valid, status, result_handle, is_top, top_valid, top_handle,
                slot_owner_out, slot_ref_out, output ready);
endinterface

FILE: sv/wsom_ram.sv
module wsom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/wsom_out_stage.sv
module wsom_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsom_pkg::result_t result,
  output logic              can_take,
  wsom_rsp_if.source        rsp
);

  logic              valid;
  wsom_pkg::result_t word;

  // holds one word; a new one may enter as the old one leaves
  assign can_take = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word <= result;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.status         = word.status;
  assign rsp.result_handle  = word.result_handle;
  assign rsp.is_top         = word.is_top;
  assign rsp.top_valid      = word.top_valid;
  assign rsp.top_handle     = word.top_handle;
  assign rsp.slot_owner_out = word.slot_owner_out;
  assign rsp.slot_ref_out   = word.slot_ref_out;

endmodule

FILE: sv/window_stacking_order_manager_core.sv
// Window stacking order manager: a pool of SLOTS window slots and their
// stacking order, bottom to top.
// req channel: one command word (opcode, handle, owner_id, window_ref).
//   create takes the lowest free slot, delete frees a listed slot,
//   update reports on a slot, raise moves a listed slot to the top.
// rsp channel: one result word per command (status, handle, top info and
//   the stored owner/reference of the result slot).
// One command at a time; req.ready is high only while the sequencer idles.
// Update, raise of the current top, and any unlisted handle go straight to
//   the result read; create walks the in-use bits for the lowest free slot,
//   and delete / raise walk the order memory, one entry per cycle.
// Reset clears the in-use bits and the open count directly; no
// clearing pass is needed and the first word is taken right after reset.
// The result sits in an output register: if rsp stalls, the next command is
// still accepted, and its result waits until the register frees up.
module window_stacking_order_manager_core #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  wsom_req_if.sink   req,
  wsom_rsp_if.source rsp
);

  localparam int IW = $clog2(SLOTS);       // slot index
  localparam int CW = $clog2(SLOTS + 1);   // open count
  localparam int AW = wsom_pkg::OWNER_W + wsom_pkg::REF_W;
  localparam int HW = wsom_pkg::HANDLE_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS);
  localparam logic [HW:0]   H_LIMIT  = (HW + 1)'(SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FREE = 6'b000010,   // walk in-use bits for the lowest free slot
    S_SCAN = 6'b000100,   // walk order memory, find handle, shift down
    S_FIX  = 6'b001000,   // close the list (append on raise, shrink on delete)
    S_RD   = 6'b010000,   // read owner/reference of the result slot
    S_RDW  = 6'b100000    // read data back, push result word
  } state_t;

  state_t                  state;
  wsom_pkg::opcode_t       op_q;
  logic [HW-1:0]           h_q;
  logic [wsom_pkg::OWNER_W-1:0] owner_q;
  logic [wsom_pkg::REF_W-1:0]   ref_q;
  logic [HW-1:0]           rh_q;
  wsom_pkg::status_t       status_q;

  logic [SLOTS-1:0]        in_use;
  logic [CW-1:0]           cnt;
  logic [IW-1:0]           top_q;

  logic [IW-1:0]           fptr;        // free-slot walk
  logic [CW-1:0]           ptr;         // order read pointer
  logic                    d_vld;       // order read data valid this cycle
  logic [CW-1:0]           d_idx;       // position of that data
  logic                    found;
  logic [IW-1:0]           below_top;   // entry just under the top

  // order memory ports
  logic                    ord_we;
  logic [IW-1:0]           ord_waddr;
  logic [IW-1:0]           ord_wdata;
  logic                    ord_re;
  logic [IW-1:0]           ord_rdata;

  // owner/reference memory ports
  logic                    att_we;
  logic                    att_re;
  logic [AW-1:0]           att_rdata;

  logic [IW-1:0]           h_idx;
  logic                    req_listed;
  logic                    free_hit;
  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           cnt_m2;
  logic [CW-1:0]           d_prev;
  logic                    scan_last;
  logic                    scan_hit;
  logic                    rh_listed;
  logic                    has_top;
  logic                    out_take;
  logic                    push;
  wsom_pkg::result_t       result;

  assign h_idx      = h_q[IW-1:0];
  assign req_listed = ({1'b0, req.handle} < H_LIMIT) && in_use[req.handle[IW-1:0]];
  assign free_hit   = !in_use[fptr];
  assign cnt_m1     = cnt - CW'(1);
  assign cnt_m2     = cnt - CW'(2);
  assign d_prev     = d_idx - CW'(1);
  assign scan_last  = d_vld && (d_idx == cnt_m1);
  assign scan_hit   = d_vld && !found && (ord_rdata == h_idx);

  assign req.ready  = (state == S_IDLE);

  // Order memory: reads run one position ahead; once the handle is seen,
  // every later entry is written one position lower. Writes stay behind
  // the read pointer, so no entry is read after being rewritten.
  assign ord_re = (state == S_SCAN) && (ptr < cnt);

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = cnt[IW-1:0];
    ord_wdata = fptr;
    case (state)
      S_FREE: begin
        ord_we    = free_hit;
        ord_waddr = cnt[IW-1:0];
        ord_wdata = fptr;
      end
      S_SCAN: begin
        ord_we    = d_vld && found;
        ord_waddr = d_prev[IW-1:0];
        ord_wdata = ord_rdata;
      end
      S_FIX: begin
        ord_we    = found && (op_q == wsom_pkg::OP_RAISE);
        ord_waddr = cnt_m1[IW-1:0];
        ord_wdata = h_idx;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  wsom_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (ord_re),
    .raddr (ptr[IW-1:0]),
    .rdata (ord_rdata)
  );

  // Owner/reference memory. Free slots read as zero through the in-use
  // bit, so delete leaves the stale entry in place.
  assign att_we = (state == S_FREE) && free_hit;
  assign att_re = (state == S_RD);

  wsom_ram #(
    .WIDTH (AW),
    .DEPTH (SLOTS)
  ) u_attr_ram (
    .clk   (clk),
    .we    (att_we),
    .waddr (fptr),
    .wdata ({owner_q, ref_q}),
    .re    (att_re),
    .raddr (rh_q[IW-1:0]),
    .rdata (att_rdata)
  );

  // result word, built from state after the command
  assign rh_listed = ({1'b0, rh_q} < H_LIMIT) && in_use[rh_q[IW-1:0]];
  assign has_top   = (cnt != '0);

  always_comb begin
    result.status         = status_q;
    result.result_handle  = rh_q;
    result.is_top         = has_top && rh_listed && (top_q == rh_q[IW-1:0]);
    result.top_valid      = has_top;
    result.top_handle     = has_top ? HW'(top_q) : '0;
    result.slot_owner_out = rh_listed ? att_rdata[AW-1 -: wsom_pkg::OWNER_W] : '0;
    result.slot_ref_out   = rh_listed ? att_rdata[wsom_pkg::REF_W-1:0] : '0;
  end

  assign push = (state == S_RDW) && out_take;

  wsom_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .result   (result),
    .can_take (out_take),
    .rsp      (rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      in_use <= '0;
      d_vld  <= 1'b0;
      found  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q     <= wsom_pkg::opcode_t'(req.opcode);
            h_q      <= req.handle;
            owner_q  <= req.owner_id;
            ref_q    <= req.window_ref;
            rh_q     <= req.handle;
            fptr     <= '0;
            ptr      <= '0;
            d_vld    <= 1'b0;
            found    <= 1'b0;
            status_q <= wsom_pkg::ST_OK;
            if (req.opcode == wsom_pkg::OP_CREATE) begin
              if (cnt == CNT_FULL) begin
                status_q <= wsom_pkg::ST_FULL;
                state    <= S_RD;
              end else begin
                state <= S_FREE;
              end
            end else if (!req_listed) begin
              status_q <= wsom_pkg::ST_NOT_FOUND;
              state    <= S_RD;
            end else if ((req.opcode == wsom_pkg::OP_UPDATE) ||
                         ((req.opcode == wsom_pkg::OP_RAISE) &&
                          (top_q == req.handle[IW-1:0]))) begin
              // update, or raise of the top: nothing moves
              state <= S_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_FREE: begin
          if (free_hit) begin
            in_use[fptr] <= 1'b1;
            cnt          <= cnt + CW'(1);
            top_q        <= fptr;
            rh_q         <= HW'(fptr);
            state        <= S_RD;
          end else begin
            fptr <= fptr + IW'(1);
          end
        end

        S_SCAN: begin
          d_vld <= ord_re;
          d_idx <= ptr;
          if (ord_re) begin
            ptr <= ptr + CW'(1);
          end
          if (scan_hit) begin
            found <= 1'b1;
          end
          if (d_vld && (d_idx == cnt_m2)) begin
            below_top <= ord_rdata;
          end
          if (scan_last) begin
            d_vld <= 1'b0;
            state <= S_FIX;
          end
        end

        S_FIX: begin
          if (!found) begin
            status_q <= wsom_pkg::ST_NOT_FOUND;
          end else if (op_q == wsom_pkg::OP_DELETE) begin
            cnt           <= cnt_m1;
            in_use[h_idx] <= 1'b0;
            if (top_q == h_idx) begin
              top_q <= below_top;
            end
          end else begin
            top_q <= h_idx;
          end
          state <= S_RD;
        end

        S_RD: begin
          state <= S_RDW;
        end

        S_RDW: begin
          if (out_take) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("open count above pool size");

  a_cnt_matches_pool: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(cnt))
    else $error("open count out of step with in-use bits");

  a_top_in_use: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> in_use[top_q])
    else $error("top slot is not in use");

  a_shift_behind_read: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && ord_we) |-> (d_prev < ptr))
    else $error("order shift overtook read pointer");
`endif

endmodule
